FILE: hdl/kvt_pkg.sv
`timescale 1ns / 1ps

package kvt_pkg;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // value split: bytes 0..6 high, bytes 7..14 low, byte 0 most significant
    localparam int VALUE_HIGH_W = 56;
    localparam int VALUE_LOW_W  = 64;
    localparam int VALUE_W      = VALUE_HIGH_W + VALUE_LOW_W;

    // one table word: valid bit on top of the 120-bit value
    localparam int ENTRY_W = VALUE_W + 1;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [ENTRY_W-1:0] entry_t;

endpackage

FILE: hdl/keyed_value_table_min_max.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_operation, s_key, s_value_high, s_value_low
// m_       out        m_valid/m_ready    m_entry_count, m_max_key, m_min_key,
//                                        m_max_value_high/low, m_min_value_high/low
//
// Insert and delete raise m_valid after accept through a read of the entry, a write back
// and a result load; s_ready comes back with it, so the next beat can go once the result is loaded.
// A query walks the single table read port one entry a cycle, then drains the last read and
// loads the result. After reset a clearing pass writes every entry once, with s_ready low.
// s_ready is high only between items; a result held by a stalled m_ready does not block
// the next beat, but that beat's result waits until the previous one is taken.

module keyed_value_table_min_max #(
    parameter int KEY_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_operation,
    input  logic [KEY_BITS-1:0]               s_key,
    input  logic [kvt_pkg::VALUE_HIGH_W-1:0]  s_value_high,
    input  logic [kvt_pkg::VALUE_LOW_W-1:0]   s_value_low,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [KEY_BITS:0]                 m_entry_count,
    output logic [KEY_BITS-1:0]               m_max_key,
    output logic [KEY_BITS-1:0]               m_min_key,
    output logic [kvt_pkg::VALUE_HIGH_W-1:0]  m_max_value_high,
    output logic [kvt_pkg::VALUE_LOW_W-1:0]   m_max_value_low,
    output logic [kvt_pkg::VALUE_HIGH_W-1:0]  m_min_value_high,
    output logic [kvt_pkg::VALUE_LOW_W-1:0]   m_min_value_low
);

    localparam int DEPTH = 1 << KEY_BITS;
    localparam int CNT_W = KEY_BITS + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP
    } state_t;

    // table: valid bit and value per key
    kvt_pkg::entry_t mem [DEPTH];

    logic                  mem_we;
    logic [KEY_BITS-1:0]   mem_waddr;
    kvt_pkg::entry_t       mem_wdata;
    logic [KEY_BITS-1:0]   mem_raddr;
    kvt_pkg::entry_t       rd_data_reg;

    state_t                state_reg,    state_next;
    logic [KEY_BITS-1:0]   cnt_reg,      cnt_next;
    logic [CNT_W-1:0]      count_reg,    count_next;
    logic [1:0]            op_reg,       op_next;
    logic [KEY_BITS-1:0]   key_reg,      key_next;
    kvt_pkg::value_t       value_reg,    value_next;

    // scan pipeline: key of the word now on the read port output
    logic                  live_reg,     live_next;
    logic [KEY_BITS-1:0]   key_d_reg,    key_d_next;

    // running extremes
    logic [KEY_BITS-1:0]   max_key_reg,  max_key_next;
    logic [KEY_BITS-1:0]   min_key_reg,  min_key_next;
    kvt_pkg::value_t       max_val_reg,  max_val_next;
    kvt_pkg::value_t       min_val_reg,  min_val_next;

    // result register
    logic                  m_valid_reg,  m_valid_next;
    logic [CNT_W-1:0]      m_count_reg,  m_count_next;
    logic [KEY_BITS-1:0]   m_max_key_reg, m_max_key_next;
    logic [KEY_BITS-1:0]   m_min_key_reg, m_min_key_next;
    kvt_pkg::value_t       m_max_val_reg, m_max_val_next;
    kvt_pkg::value_t       m_min_val_reg, m_min_val_next;

    kvt_pkg::value_t       rd_value;
    logic                  rd_valid;

    assign rd_value = rd_data_reg[kvt_pkg::VALUE_W-1:0];
    assign rd_valid = rd_data_reg[kvt_pkg::VALUE_W];

    assign s_ready = (state_reg == ST_IDLE);

    assign m_valid          = m_valid_reg;
    assign m_entry_count    = m_count_reg;
    assign m_max_key        = m_max_key_reg;
    assign m_min_key        = m_min_key_reg;
    assign m_max_value_high = m_max_val_reg[kvt_pkg::VALUE_W-1:kvt_pkg::VALUE_LOW_W];
    assign m_max_value_low  = m_max_val_reg[kvt_pkg::VALUE_LOW_W-1:0];
    assign m_min_value_high = m_min_val_reg[kvt_pkg::VALUE_W-1:kvt_pkg::VALUE_LOW_W];
    assign m_min_value_low  = m_min_val_reg[kvt_pkg::VALUE_LOW_W-1:0];

    // table port: one write, one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        live_next      = 1'b0;
        key_d_next     = cnt_reg;
        max_key_next   = max_key_reg;
        min_key_next   = min_key_reg;
        max_val_next   = max_val_reg;
        min_val_next   = min_val_reg;
        m_valid_next   = m_valid_reg;
        m_count_next   = m_count_reg;
        m_max_key_next = m_max_key_reg;
        m_min_key_next = m_min_key_reg;
        m_max_val_next = m_max_val_reg;
        m_min_val_next = m_min_val_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_wdata      = '0;
        mem_raddr      = cnt_reg;

        // compare unit: fold the word read last cycle into the extremes
        if (live_reg && rd_valid) begin
            max_key_next = key_d_reg;  // keys arrive in ascending order
            if (key_d_reg < min_key_reg) begin
                min_key_next = key_d_reg;
            end
            if (rd_value > max_val_reg) begin
                max_val_next = rd_value;
            end
            if (rd_value < min_val_reg) begin
                min_val_next = rd_value;
            end
        end

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (&cnt_reg) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_operation;
                    key_next   = s_key;
                    value_next = {s_value_high, s_value_low};
                    if (s_operation == kvt_pkg::OP_QUERY) begin
                        max_key_next = '0;
                        min_key_next = '1;
                        max_val_next = '0;
                        min_val_next = '1;
                        cnt_next     = '0;
                        state_next   = ST_SCAN;
                    end else begin
                        max_key_next = '0;
                        min_key_next = '0;
                        max_val_next = '0;
                        min_val_next = '0;
                        if (s_operation == kvt_pkg::OP_INSERT ||
                            s_operation == kvt_pkg::OP_DELETE) begin
                            state_next = ST_LOOK;
                        end else begin
                            state_next = ST_RESP;
                        end
                    end
                end
            end
            ST_LOOK: begin
                mem_raddr  = key_reg;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                mem_waddr = key_reg;
                if (op_reg == kvt_pkg::OP_INSERT) begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, value_reg};
                    if (!rd_valid) begin
                        count_next = count_reg + 1'b1;
                    end
                end else if (rd_valid) begin
                    mem_we     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_SCAN: begin
                live_next = 1'b1;
                if (&cnt_reg) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_count_next   = count_reg;
                    m_max_key_next = max_key_reg;
                    m_min_key_next = min_key_reg;
                    m_max_val_next = max_val_reg;
                    m_min_val_next = min_val_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            count_reg   <= '0;
            live_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            count_reg   <= count_next;
            live_reg    <= live_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg        <= op_next;
        key_reg       <= key_next;
        value_reg     <= value_next;
        key_d_reg     <= key_d_next;
        max_key_reg   <= max_key_next;
        min_key_reg   <= min_key_next;
        max_val_reg   <= max_val_next;
        min_val_reg   <= min_val_next;
        m_count_reg   <= m_count_next;
        m_max_key_reg <= m_max_key_next;
        m_min_key_reg <= m_min_key_next;
        m_max_val_reg <= m_max_val_next;
        m_min_val_reg <= m_min_val_next;
    end

    // count never passes the table depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    // scan words are folded in only while scanning or draining
    assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("scan pipeline live outside a query");

    // a new result appears only out of the response state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg || m_ready) && state_reg == ST_RESP |=> m_valid_reg)
        else $error("response not loaded into a free result slot");

    // a held result blocks the next one
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RESP && m_valid_reg && !m_ready |=> state_reg == ST_RESP)
        else $error("result overwritten while stalled");

endmodule
